### hdl/fcs_pkg.sv
// shared types, constants and helpers for the fast corner score block
package fcs_pkg;

  localparam int RING_SIZE  = 16;
  localparam int HALF_RING  = RING_SIZE / 2;
  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int ARC_W      = 5;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DARK   = 2'd1,
    KIND_BRIGHT = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 1'b0,
    CFG_ARC_LENGTH = 1'b1
  } cfg_idx_e;

  // handed from the quick-test stage to the arc/score stage
  typedef struct packed {
    kind_e                        kind;
    logic [RING_SIZE-1:0]         dark;
    logic [RING_SIZE-1:0]         bright;
    pix_t                         part;
    pix_t [HALF_RING-1:0]         tail;
  } mid_t;

  function automatic pix_t abs_step(pix_t s, pix_t p);
    pix_t r;
    r = (s >= p) ? (s - p) : (p - s);
    return r;
  endfunction

endpackage

### hdl/fcs_quick.sv
// stage one: per-pixel dark/bright masks, quick class and first half of the score chain
module fcs_quick
  import fcs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  pix_t                  center_i,
  input  pix_t [RING_SIZE-1:0]  ring_i,
  input  logic [THR_W-1:0]      threshold_i,
  output logic                  valid_o,
  output mid_t                  mid_o
);

  logic [RING_SIZE-1:0] dark;
  logic [RING_SIZE-1:0] bright;
  kind_e                kind;
  pix_t                 chain;
  mid_t                 mid_d;
  mid_t                 mid_q;
  logic                 valid_q;

  // 9-bit compares keep center-threshold and center+threshold exact
  always_comb begin
    for (int k = 0; k < RING_SIZE; k++) begin
      dark[k]   = {1'b0, center_i} >= ({1'b0, ring_i[k]} + {1'b0, threshold_i});
      bright[k] = ({1'b0, center_i} + {1'b0, threshold_i}) <= {1'b0, ring_i[k]};
    end
  end

  always_comb begin
    priority if (dark[0] && dark[4] && dark[8]) begin
      kind = KIND_DARK;
    end else if (bright[0] && bright[4] && bright[8]) begin
      kind = KIND_BRIGHT;
    end else if (dark[4] && dark[8] && dark[12]) begin
      kind = KIND_DARK;
    end else if (bright[4] && bright[8] && bright[12]) begin
      kind = KIND_BRIGHT;
    end else if (dark[8] && dark[12] && dark[0]) begin
      kind = KIND_DARK;
    end else if (bright[8] && bright[12] && bright[0]) begin
      kind = KIND_BRIGHT;
    end else if (dark[12] && dark[0] && dark[4]) begin
      kind = KIND_DARK;
    end else if (bright[12] && bright[0] && bright[4]) begin
      kind = KIND_BRIGHT;
    end else begin
      kind = KIND_NONE;
    end
  end

  always_comb begin
    chain = center_i;
    for (int k = 0; k < HALF_RING; k++) begin
      chain = abs_step(chain, ring_i[k]);
    end
  end

  always_comb begin
    mid_d.kind   = kind;
    mid_d.dark   = dark;
    mid_d.bright = bright;
    mid_d.part   = chain;
    for (int k = 0; k < HALF_RING; k++) begin
      mid_d.tail[k] = ring_i[HALF_RING + k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;

endmodule

### hdl/fcs_final.sv
// stage two: arc search over the ring mask, second half of the score chain, result register
module fcs_final
  import fcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mid_t              mid_i,
  input  logic [ARC_W-1:0]  arc_length_i,
  output logic              valid_o,
  output pix_t              score_o,
  output kind_e             kind_o
);

  logic [RING_SIZE-1:0]   sel;
  logic [2*RING_SIZE-1:0] dbl;
  logic [RING_SIZE-1:0]   len_mask;
  logic [ARC_W-1:0]       len;
  logic                   arc_found;
  pix_t                   chain;
  pix_t                   score_d;
  kind_e                  kind_d;
  pix_t                   score_q;
  kind_e                  kind_q;
  logic                   valid_q;

  always_comb begin
    sel = (mid_i.kind == KIND_DARK) ? mid_i.dark : mid_i.bright;
    dbl = {sel, sel};
    len = (arc_length_i > ARC_W'(RING_SIZE)) ? ARC_W'(RING_SIZE) : arc_length_i;
    for (int k = 0; k < RING_SIZE; k++) begin
      len_mask[k] = ARC_W'(k) < len;
    end
    arc_found = 1'b0;
    for (int s = 0; s < RING_SIZE; s++) begin
      if ((dbl[s +: RING_SIZE] & len_mask) == len_mask) begin
        arc_found = 1'b1;
      end
    end
  end

  always_comb begin
    chain = mid_i.part;
    for (int k = 0; k < HALF_RING; k++) begin
      chain = abs_step(chain, mid_i.tail[k]);
    end
  end

  always_comb begin
    score_d = ((mid_i.kind != KIND_NONE) && arc_found) ? chain : '0;
    kind_d  = (score_d == '0) ? KIND_NONE : mid_i.kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      score_q <= score_d;
      kind_q  <= kind_d;
    end
  end

  assign valid_o = valid_q;
  assign score_o = score_q;
  assign kind_o  = kind_q;

endmodule

### hdl/fast_corner_score.sv
// top level of the fast corner score block: config registers, input register, pipeline control
//
// One candidate pixel and its 16-pixel ring enter per transaction, and the block accepts
// one transaction every clock while the output side keeps taking results. Each accepted
// input passes in order through the input register, a stage that forms the dark/bright
// ring masks, the quick class and the first eight steps of the chained score, and a
// result register that follows the arc search and the last eight chain steps.
// A stalled output holds its result and backs up the stages behind it; ready falls only
// when all three stages are full and the output is not taken. Write threshold and
// arc_length only while no transaction is in flight.
module fast_corner_score
  import fcs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PIX_W-1:0]       center_pixel_i,
  input  logic [31:0]            ring_a_i,
  input  logic [31:0]            ring_b_i,
  input  logic [31:0]            ring_c_i,
  input  logic [31:0]            ring_d_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PIX_W-1:0]       corner_score_o,
  output logic [1:0]             corner_kind_o
);

  logic [THR_W-1:0]      threshold_q;
  logic [ARC_W-1:0]      arc_length_q;
  logic                  in_valid_q;
  pix_t                  center_q;
  pix_t [RING_SIZE-1:0]  ring_d;
  pix_t [RING_SIZE-1:0]  ring_q;
  logic                  en_in;
  logic                  en_mid;
  logic                  en_out;
  logic                  mid_valid;
  mid_t                  mid;
  kind_e                 kind;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THR_W'(20);
      arc_length_q <= ARC_W'(9);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i[THR_W-1:0];
        CFG_ARC_LENGTH: arc_length_q <= cfg_data_i[ARC_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables, back to front
  assign en_out     = !out_valid_o || out_ready_i;
  assign en_mid     = !mid_valid || en_out;
  assign en_in      = !in_valid_q || en_mid;
  assign in_ready_o = en_in;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ring_d[k]      = ring_a_i[8*k +: 8];
      ring_d[4 + k]  = ring_b_i[8*k +: 8];
      ring_d[8 + k]  = ring_c_i[8*k +: 8];
      ring_d[12 + k] = ring_d_i[8*k +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && in_valid_i) begin
      center_q <= center_pixel_i;
      ring_q   <= ring_d;
    end
  end

  fcs_quick u_quick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_mid),
    .valid_i     (in_valid_q),
    .center_i    (center_q),
    .ring_i      (ring_q),
    .threshold_i (threshold_q),
    .valid_o     (mid_valid),
    .mid_o       (mid)
  );

  fcs_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en_out),
    .valid_i      (mid_valid),
    .mid_i        (mid),
    .arc_length_i (arc_length_q),
    .valid_o      (out_valid_o),
    .score_o      (corner_score_o),
    .kind_o       (kind)
  );

  assign corner_kind_o = kind;

  a_score_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((corner_score_o == '0) == (kind == KIND_NONE)))
    else $error("score and kind disagree");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && mid_valid && in_valid_q))
    else $error("ready low without a full stalled pipeline");

  a_out_from_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(mid_valid))
    else $error("result appeared without a stage-one transaction");

  a_mid_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mid_valid) |-> $past(in_valid_q))
    else $error("stage one filled without an input transaction");

endmodule
